### rtl/dqo_pkg.sv
// Shared types, constants and transition tables for the dual quadrature odometry block.
package dqo_pkg;

    localparam int COUNT_WIDTH_DEF = 32;

    // Stream and configuration widths
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 136;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_EDGE_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_SPEED        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BATTERY_WINDOWS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BATTERY_LOW_CODE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BATTERY_HIGH_CODE = 3'd5;

    // Register values after reset
    localparam logic        RST_FULL_EDGE_MODE    = 1'b1;
    localparam logic [15:0] RST_WINDOW_TICKS      = 16'd100;
    localparam logic [15:0] RST_STOP_SPEED        = 16'd40;
    localparam logic [7:0]  RST_BATTERY_WINDOWS   = 8'd10;
    localparam logic [9:0]  RST_BATTERY_LOW_CODE  = 10'd316;
    localparam logic [9:0]  RST_BATTERY_HIGH_CODE = 10'd643;

    typedef struct packed {
        logic        full_edge_mode;
        logic [15:0] window_ticks;
        logic [15:0] stop_speed;
        logic [7:0]  battery_windows;
        logic [9:0]  battery_low_code;
        logic [9:0]  battery_high_code;
    } cfg_t;

    // Full-edge transition table, index = {prev_a, prev_b, cur_a, cur_b}
    function automatic logic signed [1:0] x4_delta(input logic [3:0] idx);
        logic signed [1:0] d;
        case (idx)
            4'd1, 4'd7, 4'd8, 4'd14: d = -2'sd1;
            4'd2, 4'd4, 4'd11, 4'd13: d = 2'sd1;
            default:                  d = 2'sd0;
        endcase
        return d;
    endfunction

    // A-edge transition table
    function automatic logic signed [1:0] x2_delta(input logic [3:0] idx);
        logic signed [1:0] d;
        case (idx)
            4'd3, 4'd12: d = -2'sd1;
            4'd6, 4'd9:  d = 2'sd1;
            default:     d = 2'sd0;
        endcase
        return d;
    endfunction

endpackage

### rtl/dual_quadrature_odometry.sv
// Top level of the dual quadrature odometry block: ports, config, word registers.
//
//  channel  dir  handshake            payload
//  s_       in   s_tvalid/s_tready    s_tdata: pin sample, tick, battery code, resume
//  m_       out  m_tvalid/m_tready    m_tdata: counts, speed, target, flags; m_tlast
//  cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One word per cycle sustained while m_tready stays high; a result word passes the input
// register, one pass of decode/window logic and the result register before it is valid on m_.
// aresetn clears counts, window state and flags and loads the register defaults.
// While m_tready is low the result register holds and the input register takes
// one more word; s_tready then drops until the result is taken.
module dual_quadrature_odometry #(
    parameter int COUNT_WIDTH = dqo_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // left_a, left_b, right_a, right_b, ms_tick, battery_code[9:0], resume
    input  logic [dqo_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // left_count[31:0], right_count[31:0], speed[31:0], target_position[31:0],
    // stopped_flag, buzzer_on, zero fill
    output logic [dqo_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                           m_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dqo_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dqo_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dqo_pkg::*;

    cfg_t                cfg_reg;
    logic                in_valid_reg;
    logic [S_DATA_W-1:0] in_data_reg;
    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic                out_last_reg;
    logic                fire;

    logic [31:0] left_count, right_count, speed, target_position;
    logic        stopped_flag, buzzer_on, window_done;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.full_edge_mode    <= RST_FULL_EDGE_MODE;
            cfg_reg.window_ticks      <= RST_WINDOW_TICKS;
            cfg_reg.stop_speed        <= RST_STOP_SPEED;
            cfg_reg.battery_windows   <= RST_BATTERY_WINDOWS;
            cfg_reg.battery_low_code  <= RST_BATTERY_LOW_CODE;
            cfg_reg.battery_high_code <= RST_BATTERY_HIGH_CODE;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_FULL_EDGE_MODE:    cfg_reg.full_edge_mode    <= cfg_data[0];
                CFG_WINDOW_TICKS:      cfg_reg.window_ticks      <= cfg_data;
                CFG_STOP_SPEED:        cfg_reg.stop_speed        <= cfg_data;
                CFG_BATTERY_WINDOWS:   cfg_reg.battery_windows   <= cfg_data[7:0];
                CFG_BATTERY_LOW_CODE:  cfg_reg.battery_low_code  <= cfg_data[9:0];
                CFG_BATTERY_HIGH_CODE: cfg_reg.battery_high_code <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // advance a word when the result register is free or being emptied
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
        end
    end

    dqo_wheel #(.COUNT_WIDTH(COUNT_WIDTH)) u_left (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (fire),
        .full_edge_mode (cfg_reg.full_edge_mode),
        .pin_a          (in_data_reg[0]),
        .pin_b          (in_data_reg[1]),
        .count_next     (left_count)
    );

    dqo_wheel #(.COUNT_WIDTH(COUNT_WIDTH)) u_right (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (fire),
        .full_edge_mode (cfg_reg.full_edge_mode),
        .pin_a          (in_data_reg[2]),
        .pin_b          (in_data_reg[3]),
        .count_next     (right_count)
    );

    dqo_window u_window (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .en              (fire),
        .cfg             (cfg_reg),
        .ms_tick         (in_data_reg[4]),
        .battery_code    (in_data_reg[14:5]),
        .resume          (in_data_reg[15]),
        .left_count      (left_count),
        .right_count     (right_count),
        .speed           (speed),
        .target_position (target_position),
        .stopped_flag    (stopped_flag),
        .buzzer_on       (buzzer_on),
        .window_done     (window_done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= {6'd0, buzzer_on, stopped_flag, target_position, speed,
                             right_count, left_count};
            out_last_reg <= window_done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |-> !fire)
        else $error("result register overwritten while stalled");

endmodule

### rtl/dqo_wheel.sv
// One wheel: quadrature transition decode and wrapping edge counter.
module dqo_wheel #(
    parameter int COUNT_WIDTH = dqo_pkg::COUNT_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        full_edge_mode,
    input  logic        pin_a,
    input  logic        pin_b,
    output logic [31:0] count_next
);
    import dqo_pkg::*;

    logic [1:0]             prev_reg;
    logic [1:0]             prev_next;
    logic [COUNT_WIDTH-1:0] total_reg;
    logic [COUNT_WIDTH-1:0] total_next;
    logic [3:0]             idx;
    logic signed [1:0]      delta;
    logic                   step;

    assign idx = {prev_reg, pin_a, pin_b};

    always_comb begin
        if (full_edge_mode) begin
            step  = 1'b1;
            delta = x4_delta(idx);
        end else begin
            // count only when A changed level
            step  = (prev_reg[1] != pin_a);
            delta = x2_delta(idx);
        end
        if (step) begin
            total_next = total_reg + {{(COUNT_WIDTH-2){delta[1]}}, delta};
            prev_next  = {pin_a, pin_b};
        end else begin
            total_next = total_reg;
            prev_next  = prev_reg;
        end
    end

    generate
        if (COUNT_WIDTH >= 32) begin : g_trunc
            assign count_next = total_next[31:0];
        end else begin : g_sext
            assign count_next = {{(32-COUNT_WIDTH){total_next[COUNT_WIDTH-1]}}, total_next};
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg  <= '0;
            total_reg <= '0;
        end else if (en) begin
            prev_reg  <= prev_next;
            total_reg <= total_next;
        end
    end

    a_hold_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$past(en) |-> $stable(total_reg) && $stable(prev_reg))
        else $error("wheel count moved without an accepted word");

endmodule

### rtl/dqo_window.sv
// Velocity window, stop latch and battery check.
module dqo_window (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  dqo_pkg::cfg_t cfg,
    input  logic          ms_tick,
    input  logic [9:0]    battery_code,
    input  logic          resume,
    input  logic [31:0]   left_count,
    input  logic [31:0]   right_count,
    output logic [31:0]   speed,
    output logic [31:0]   target_position,
    output logic          stopped_flag,
    output logic          buzzer_on,
    output logic          window_done
);
    import dqo_pkg::*;

    logic [15:0] tick_count_reg, tick_count_next;
    logic [7:0]  window_count_reg, window_count_next;
    logic [31:0] last_sum_reg, last_sum_next;
    logic [31:0] speed_reg, speed_next;
    logic [31:0] target_reg, target_next;
    logic        stop_reg, stop_next;
    logic        buzzer_reg, buzzer_next;

    logic [16:0] tick_inc;
    logic [8:0]  win_inc;
    logic        close;
    logic        batt_check;
    logic [31:0] sum;
    logic [31:0] speed_new;
    logic [31:0] mag;
    logic        stop_cleared;
    logic        latch;
    logic        in_window;

    always_comb begin
        tick_inc     = {1'b0, tick_count_reg} + 17'd1;
        close        = ms_tick && (tick_inc >= {1'b0, cfg.window_ticks});
        win_inc      = {1'b0, window_count_reg} + 9'd1;
        batt_check   = close && (win_inc >= {1'b0, cfg.battery_windows});
        sum          = left_count + right_count;
        speed_new    = sum - last_sum_reg;
        mag          = speed_new[31] ? (32'd0 - speed_new) : speed_new;
        stop_cleared = resume ? 1'b0 : stop_reg;
        latch        = close && (mag <= {16'd0, cfg.stop_speed}) && !stop_cleared;
        in_window    = (battery_code >= cfg.battery_low_code) &&
                       (battery_code <= cfg.battery_high_code);

        if (!ms_tick) begin
            tick_count_next = tick_count_reg;
        end else if (close) begin
            tick_count_next = '0;
        end else begin
            tick_count_next = tick_inc[15:0];
        end

        if (!close) begin
            window_count_next = window_count_reg;
        end else if (batt_check) begin
            window_count_next = '0;
        end else begin
            window_count_next = win_inc[7:0];
        end

        last_sum_next = close ? sum : last_sum_reg;
        speed_next    = close ? speed_new : speed_reg;
        target_next   = latch ? sum : target_reg;
        stop_next     = latch ? 1'b1 : stop_cleared;
        buzzer_next   = batt_check ? in_window : buzzer_reg;
    end

    assign speed           = speed_next;
    assign target_position = target_next;
    assign stopped_flag    = stop_next;
    assign buzzer_on       = buzzer_next;
    assign window_done     = close;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg   <= '0;
            window_count_reg <= '0;
            last_sum_reg     <= '0;
            speed_reg        <= '0;
            target_reg       <= '0;
            stop_reg         <= 1'b0;
            buzzer_reg       <= 1'b0;
        end else if (en) begin
            tick_count_reg   <= tick_count_next;
            window_count_reg <= window_count_next;
            last_sum_reg     <= last_sum_next;
            speed_reg        <= speed_next;
            target_reg       <= target_next;
            stop_reg         <= stop_next;
            buzzer_reg       <= buzzer_next;
        end
    end

    a_tick_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        en && close |=> tick_count_reg == '0)
        else $error("tick counter not cleared at window close");

    a_stop_at_close: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $rose(stop_reg) |-> $past(en && close))
        else $error("stop latch set outside a window close");

    // resume and a new latch in one word keep stop_reg high while the target moves
    a_target_with_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$stable(target_reg) |-> $past(en && latch))
        else $error("target moved without a stop latch");

    a_buzzer_at_check: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$stable(buzzer_reg) |-> $past(en && batt_check))
        else $error("buzzer changed outside a battery check");

endmodule

### test/dual_quadrature_odometry_tb.sv
// Self-checking testbench for the dual quadrature odometry block with its own odometry scoreboard.
`timescale 1ns / 100ps

module dual_quadrature_odometry_tb;
    import dqo_pkg::*;

    typedef struct {
        bit       left_a;
        bit       left_b;
        bit       right_a;
        bit       right_b;
        bit       ms_tick;
        bit [9:0] battery_code;
        bit       resume;
    } pin_sample_t;

    typedef struct {
        logic [31:0] left_count;
        logic [31:0] right_count;
        logic [31:0] speed;
        logic [31:0] target_position;
        logic        stopped_flag;
        logic        buzzer_on;
        logic        window_done;
    } odometry_t;

    class odometry_scoreboard;
        // register copy
        bit        full_edge;
        bit [15:0] win_ticks;
        bit [15:0] stop_thr;
        bit [7:0]  batt_windows;
        bit [9:0]  batt_low;
        bit [9:0]  batt_high;
        // block state
        bit [1:0]  left_pins;
        bit [1:0]  right_pins;
        bit [31:0] left_pos;
        bit [31:0] right_pos;
        bit [31:0] prev_sum;
        bit [31:0] win_speed;
        bit [31:0] target;
        bit        stopped;
        bit        buzzer;
        bit [15:0] tick_cnt;
        bit [7:0]  win_cnt;

        int          step_x4[16];
        int          step_x2[16];
        odometry_t   pending[$];
        int unsigned errors;
        int unsigned report_limit;

        function new();
            step_x4 = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};
            step_x2 = '{0, 0, 0, -1, 0, 0, 1, 0, 0, 1, 0, 0, -1, 0, 0, 0};
            full_edge    = 1'b1;
            win_ticks    = 16'd100;
            stop_thr     = 16'd40;
            batt_windows = 8'd10;
            batt_low     = 10'd316;
            batt_high    = 10'd643;
            left_pins    = '0;
            right_pins   = '0;
            left_pos     = '0;
            right_pos    = '0;
            prev_sum     = '0;
            win_speed    = '0;
            target       = '0;
            stopped      = 1'b0;
            buzzer       = 1'b0;
            tick_cnt     = '0;
            win_cnt      = '0;
            errors       = 0;
            report_limit = 40;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_FULL_EDGE_MODE:    full_edge    = val[0];
                CFG_WINDOW_TICKS:      win_ticks    = val;
                CFG_STOP_SPEED:        stop_thr     = val;
                CFG_BATTERY_WINDOWS:   batt_windows = val[7:0];
                CFG_BATTERY_LOW_CODE:  batt_low     = val[9:0];
                CFG_BATTERY_HIGH_CODE: batt_high    = val[9:0];
                default: ;
            endcase
        endfunction

        function void step_wheel(inout bit [1:0] pins, inout bit [31:0] pos,
                                 input bit a, input bit b);
            bit [3:0] idx;
            idx = {pins, a, b};
            if (full_edge) begin
                pos = pos + step_x4[idx];
            end else begin
                // half-rate decoding ignores samples where A holds its level
                if (pins[1] == a) return;
                pos = pos + step_x2[idx];
            end
            pins = {a, b};
        endfunction

        function void take_sample(pin_sample_t smp);
            odometry_t res;
            bit [31:0] sum;
            bit [31:0] mag;
            int        t;
            int        w;
            res.window_done = 1'b0;
            step_wheel(left_pins, left_pos, smp.left_a, smp.left_b);
            step_wheel(right_pins, right_pos, smp.right_a, smp.right_b);
            if (smp.resume) stopped = 1'b0;
            if (smp.ms_tick) begin
                t = tick_cnt + 1;
                if (t >= win_ticks) begin
                    tick_cnt        = '0;
                    res.window_done = 1'b1;
                    sum       = left_pos + right_pos;
                    win_speed = sum - prev_sum;
                    prev_sum  = sum;
                    mag = win_speed[31] ? 32'd0 - win_speed : win_speed;
                    // keep an existing target until resume clears the latch
                    if (mag <= stop_thr && !stopped) begin
                        target  = sum;
                        stopped = 1'b1;
                    end
                    w = win_cnt + 1;
                    if (w >= batt_windows) begin
                        win_cnt = '0;
                        buzzer  = (smp.battery_code >= batt_low) &&
                                  (smp.battery_code <= batt_high);
                    end else begin
                        win_cnt = w[7:0];
                    end
                end else begin
                    tick_cnt = t[15:0];
                end
            end
            res.left_count      = left_pos;
            res.right_count     = right_pos;
            res.speed           = win_speed;
            res.target_position = target;
            res.stopped_flag    = stopped;
            res.buzzer_on       = buzzer;
            pending.push_back(res);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                if (errors <= report_limit)
                    $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
            end
        endfunction

        function void check_odometry(odometry_t got);
            odometry_t want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= report_limit)
                    $display("%0t: result word with no expected value: expected none, got %h %h",
                             $time, got.left_count, got.right_count);
                return;
            end
            want = pending.pop_front();
            check_field("left_count", want.left_count, got.left_count);
            check_field("right_count", want.right_count, got.right_count);
            check_field("speed", want.speed, got.speed);
            check_field("target_position", want.target_position, got.target_position);
            check_field("stopped_flag", want.stopped_flag, got.stopped_flag);
            check_field("buzzer_on", want.buzzer_on, got.buzzer_on);
            check_field("window_done", want.window_done, got.window_done);
        endfunction
    endclass

    localparam int          SETTLE_CYCLES = 6;
    localparam int unsigned LIMIT_CYCLES  = 400000;
    localparam int          RANDOM_PHASES = 8;
    localparam int          PHASE_WORDS   = 88;
    // pin pairs whose successive transitions cover all sixteen table indexes
    localparam logic [31:0] EDGE_WALK     = 32'h3EB6_5C84;

    typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_ALTERNATE, RX_HOLD} rx_pattern_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    odometry_scoreboard odo;
    int unsigned        cycles = 0;
    rx_pattern_t        rx_pattern = RX_OPEN;
    int                 rx_left = 0;
    int                 burst_left = 0;
    int                 tick_pct = 50;
    bit [1:0]           left_walk = '0;
    bit [1:0]           right_walk = '0;
    int                 left_dir = 1;
    int                 right_dir = -1;

    dual_quadrature_odometry DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("** dual_quadrature_odometry: FAILED **");
            $finish;
        end
    end

    // receiver: segments of open, random, alternating and held-off ready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_pattern = rx_pattern_t'($urandom_range(0, 4));
                rx_left    = (rx_pattern == RX_HOLD) ? $urandom_range(1, 8)
                                                     : $urandom_range(10, 60);
            end
            rx_left--;
            case (rx_pattern)
                RX_OPEN:      m_tready <= 1'b1;
                RX_LIGHT:     m_tready <= ($urandom_range(0, 3) != 0);
                RX_HEAVY:     m_tready <= ($urandom_range(0, 2) == 0);
                RX_ALTERNATE: m_tready <= cycles[0];
                default:      m_tready <= 1'b0;
            endcase
        end
    end

    always @(posedge aclk) begin
        odometry_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.left_count      = m_tdata[31:0];
            got.right_count     = m_tdata[63:32];
            got.speed           = m_tdata[95:64];
            got.target_position = m_tdata[127:96];
            got.stopped_flag    = m_tdata[128];
            got.buzzer_on       = m_tdata[129];
            got.window_done     = m_tlast;
            odo.check_odometry(got);
        end
    end

    function automatic bit [1:0] gray(bit [1:0] pos);
        return {pos[1], pos[1] ^ pos[0]};
    endfunction

    // mostly legal quadrature steps with direction changes, some random jumps
    function automatic bit [1:0] wheel_pins(inout bit [1:0] pos, inout int dir);
        bit [1:0] pins;
        if ($urandom_range(0, 99) < 10) dir = $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 99) < 12) begin
            pins = 2'($urandom_range(0, 3));
            pos  = gray(pins);
        end else begin
            pos  = pos + dir[1:0];
            pins = gray(pos);
        end
        return pins;
    endfunction

    function automatic pin_sample_t next_sample();
        pin_sample_t smp;
        bit [1:0]    lp;
        bit [1:0]    rp;
        lp = wheel_pins(left_walk, left_dir);
        rp = wheel_pins(right_walk, right_dir);
        smp.left_a  = lp[1];
        smp.left_b  = lp[0];
        smp.right_a = rp[1];
        smp.right_b = rp[0];
        smp.ms_tick = ($urandom_range(0, 99) < tick_pct);
        smp.resume  = ($urandom_range(0, 99) < 6);
        // bias battery codes onto the window limits
        case ($urandom_range(0, 7))
            0:       smp.battery_code = odo.batt_low;
            1:       smp.battery_code = odo.batt_high;
            2:       smp.battery_code = odo.batt_low - 10'd1;
            3:       smp.battery_code = odo.batt_high + 10'd1;
            default: smp.battery_code = 10'($urandom_range(0, 1023));
        endcase
        return smp;
    endfunction

    task automatic send_sample(input pin_sample_t smp);
        int gap;
        s_tdata  <= {smp.resume, smp.battery_code, smp.ms_tick,
                     smp.right_b, smp.right_a, smp.left_b, smp.left_a};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        odo.take_sample(smp);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // hold off the sender until every expected result word has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (odo.pending.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        odo.set_reg(idx, val);
    endtask

    task automatic load_config(input bit full, input bit [15:0] wt, input bit [15:0] stop,
                               input bit [7:0] bw, input bit [9:0] lo, input bit [9:0] hi);
        write_reg(CFG_FULL_EDGE_MODE, {15'd0, full});
        write_reg(CFG_WINDOW_TICKS, wt);
        write_reg(CFG_STOP_SPEED, stop);
        write_reg(CFG_BATTERY_WINDOWS, {8'd0, bw});
        write_reg(CFG_BATTERY_LOW_CODE, {6'd0, lo});
        write_reg(CFG_BATTERY_HIGH_CODE, {6'd0, hi});
        cfg_valid <= 1'b0;
    endtask

    initial begin
        pin_sample_t smp;
        bit [1:0]    pins;
        int          i;
        int          p;

        odo = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings, full-edge table: every transition on both wheels
        for (i = 0; i < 16; i++) begin
            smp.left_a       = EDGE_WALK[2*i+1];
            smp.left_b       = EDGE_WALK[2*i];
            smp.right_a      = EDGE_WALK[31-2*i];
            smp.right_b      = EDGE_WALK[30-2*i];
            smp.ms_tick      = (i % 3) != 0;
            smp.battery_code = i[0] ? 10'h3FF : 10'h000;
            smp.resume       = (i == 5);
            send_sample(smp);
        end

        // A-edge table, a window and a battery check on every tick
        drain_results();
        load_config(1'b0, 16'd1, 16'd0, 8'd1, 10'd0, 10'd1023);
        for (i = 1; i <= 8; i++) begin
            pins             = gray(i[1:0]);
            smp.left_a       = pins[1];
            smp.left_b       = pins[0];
            pins             = gray(2'd0 - i[1:0]);
            smp.right_a      = pins[1];
            smp.right_b      = pins[0];
            smp.ms_tick      = 1'b1;
            smp.battery_code = (i % 3 == 0) ? 10'd512 : (i[0] ? 10'h3FF : 10'h000);
            smp.resume       = (i == 4) || (i == 7);
            send_sample(smp);
        end

        for (p = 0; p < RANDOM_PHASES; p++) begin
            drain_results();
            tick_pct = 50;
            case (p)
                0: load_config(1'b1, 16'd3, 16'd0, 8'd2, 10'd316, 10'd643);
                1: load_config(1'b0, 16'd1, 16'hFFFF, 8'd255, 10'd0, 10'd1023);
                // zero limits right after a long battery count
                2: begin
                    tick_pct = 40;
                    load_config(1'b1, 16'd0, 16'd2, 8'd0, 10'd1023, 10'd1023);
                end
                // build up a long tick count for the next phase to undercut
                3: begin
                    tick_pct = 70;
                    load_config(1'b0, 16'd200, 16'd10, 8'd1, 10'd500, 10'd600);
                end
                // window limit lowered below the tick count; inverted battery limits
                4: load_config(1'b1, 16'd2, 16'd4, 8'd3, 10'd700, 10'd300);
                5: load_config(1'b1, 16'hFFFF, 16'd40, 8'd1, 10'd316, 10'd643);
                default: load_config(1'($urandom_range(0, 1)), 16'($urandom_range(1, 6)),
                                     16'($urandom_range(0, 12)), 8'($urandom_range(1, 4)),
                                     10'($urandom_range(0, 1023)),
                                     10'($urandom_range(0, 1023)));
            endcase
            for (i = 0; i < PHASE_WORDS; i++)
                send_sample(next_sample());
        end

        drain_results();
        if (odo.errors == 0 && odo.pending.size() == 0) begin
            $display("** dual_quadrature_odometry: PASSED **");
        end else begin
            $display("** dual_quadrature_odometry: FAILED **");
        end
        $finish;
    end

endmodule
